/* design/cbds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbds_pkg
// Shared types, codes and calendar helpers for the business day stepper.
// ----------------------------------------------------------------------------
package cbds_pkg;

  localparam int CMD_W   = 3;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOW_W   = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_DEC_END = 5'd31;

  // state after reset: 1970-01-01, a thursday, common year
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd1970;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
  localparam logic [DOW_W-1:0]   RESET_DOW   = 3'd4;
  localparam logic               RESET_LEAP  = 1'b0;

  localparam logic [DOW_W-1:0] DOW_SUN = 3'd0;
  localparam logic [DOW_W-1:0] DOW_SAT = 3'd6;

  // x / 100 == (x * 5243) >> 19 for every 14-bit x
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;
  localparam logic [13:0] CENTURY    = 14'd100;
  // s / 7 == (s * 37450) >> 18 for s below 43690
  localparam logic [15:0] DIV7_MUL   = 16'd37450;
  localparam int          DIV7_SH    = 18;
  localparam logic [13:0] WEEK       = 14'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 3'd0,
    CMD_NEXT_DAY = 3'd1,
    CMD_PREV_DAY = 3'd2,
    CMD_NEXT_WD  = 3'd3,
    CMD_PREV_WD  = 3'd4
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic div;
    logic rem;
    logic mod7;
    logic clamp;
    logic emit;
  } cbds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             step_refuse;
    logic             weekday;
    logic             out_free;
  } cbds_sts_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_code(input logic [MONTH_W-1:0] m);
    logic [2:0] code;
    case (m)
      4'd1:    code = 3'd0;
      4'd2:    code = 3'd3;
      4'd3:    code = 3'd2;
      4'd4:    code = 3'd5;
      4'd5:    code = 3'd0;
      4'd6:    code = 3'd3;
      4'd7:    code = 3'd5;
      4'd8:    code = 3'd1;
      4'd9:    code = 3'd4;
      4'd10:   code = 3'd6;
      4'd11:   code = 3'd2;
      4'd12:   code = 3'd4;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

/* design/cbds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbds_in_if / cbds_out_if
// Valid/ready channels for commands and dated results.
// ----------------------------------------------------------------------------
interface cbds_in_if;
  import cbds_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [YEAR_W-1:0]   load_year;
  logic [MONTH_W-1:0]  load_month;
  logic [DAY_W-1:0]    load_day;

  modport source (output valid, command, load_year, load_month, load_day, input ready);
  modport sink   (input valid, command, load_year, load_month, load_day, output ready);
endinterface

interface cbds_out_if;
  import cbds_pkg::*;
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [DOW_W-1:0]    day_of_week;
  logic                weekday_flag;
  logic                leap_flag;
  logic                at_limit;

  modport source (output valid, year_out, month_out, day_out, day_of_week, weekday_flag,
                  leap_flag, at_limit, input ready);
  modport sink   (input valid, year_out, month_out, day_out, day_of_week, weekday_flag,
                  leap_flag, at_limit, output ready);
endinterface

/* design/cbds_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbds_datapath
// Date registers, day stepping, leap and day-of-week analysis, result register.
// ----------------------------------------------------------------------------
module cbds_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbds_pkg::cbds_cmd_t           cmd_i,
  output cbds_pkg::cbds_sts_t           sts_o,
  input  logic [cbds_pkg::CMD_W-1:0]    in_command_i,
  input  logic [cbds_pkg::YEAR_W-1:0]   in_load_year_i,
  input  logic [cbds_pkg::MONTH_W-1:0]  in_load_month_i,
  input  logic [cbds_pkg::DAY_W-1:0]    in_load_day_i,
  cbds_out_if.source                    out_o
);
  import cbds_pkg::*;

  // committed date
  logic [YEAR_W-1:0]  cur_year_q;
  logic [MONTH_W-1:0] cur_month_q;
  logic [DAY_W-1:0]   cur_day_q;
  logic [DOW_W-1:0]   cur_dow_q;
  logic               cur_leap_q;

  // working date
  logic [CMD_W-1:0]   cmd_q;
  logic [YEAR_W-1:0]  w_year_q,  w_year_d;
  logic [MONTH_W-1:0] w_month_q, w_month_d;
  logic [DAY_W-1:0]   w_day_q,   w_day_d;
  logic [DOW_W-1:0]   w_dow_q;
  logic               w_leap_q;
  logic               refused_q;

  logic [6:0]         q_y_q;
  logic [YEAR_W-1:0]  sum_q;

  logic               out_valid_q;
  logic [YEAR_W-1:0]  out_year_q;
  logic [MONTH_W-1:0] out_month_q;
  logic [DAY_W-1:0]   out_day_q;
  logic [DOW_W-1:0]   out_dow_q;
  logic               out_leap_q;
  logic               out_limit_q;

  // load saturation
  logic [YEAR_W-1:0]  ld_year;
  logic [MONTH_W-1:0] ld_month;
  logic [DAY_W-1:0]   ld_day;

  always_comb begin
    ld_year = in_load_year_i;
    if (ld_year < YEAR_MIN) ld_year = YEAR_MIN;
    if (ld_year > YEAR_MAX) ld_year = YEAR_MAX;
    ld_month = in_load_month_i;
    if (ld_month < MONTH_FIRST) ld_month = MONTH_FIRST;
    if (ld_month > MONTH_LAST) ld_month = MONTH_LAST;
    ld_day = in_load_day_i;
    if (ld_day < DAY_FIRST) ld_day = DAY_FIRST;
  end

  // day step
  logic             fwd;
  logic [DAY_W-1:0] dim_cur, dim_prev;
  logic             refuse;

  assign fwd      = (cmd_q == CMD_NEXT_DAY) || (cmd_q == CMD_NEXT_WD);
  assign dim_cur  = days_in(w_month_q, w_leap_q);
  assign dim_prev = days_in(w_month_q - 4'd1, w_leap_q);

  always_comb begin
    w_year_d  = w_year_q;
    w_month_d = w_month_q;
    w_day_d   = w_day_q;
    refuse    = 1'b0;
    if (fwd) begin
      if (w_day_q < dim_cur) begin
        w_day_d = w_day_q + 5'd1;
      end else if (w_month_q < MONTH_LAST) begin
        w_month_d = w_month_q + 4'd1;
        w_day_d   = DAY_FIRST;
      end else if (w_year_q < YEAR_MAX) begin
        w_year_d  = w_year_q + 14'd1;
        w_month_d = MONTH_FIRST;
        w_day_d   = DAY_FIRST;
      end else begin
        refuse = 1'b1;
      end
    end else begin
      if (w_day_q > DAY_FIRST) begin
        w_day_d = w_day_q - 5'd1;
      end else if (w_month_q > MONTH_FIRST) begin
        w_month_d = w_month_q - 4'd1;
        w_day_d   = dim_prev;
      end else if (w_year_q > YEAR_MIN) begin
        w_year_d  = w_year_q - 14'd1;
        w_month_d = MONTH_LAST;
        w_day_d   = DAY_DEC_END;
      end else begin
        refuse = 1'b1;
      end
    end
  end

  // analysis: year / 100
  logic [26:0] prod_y;
  assign prod_y = 27'(w_year_q) * 27'(DIV100_MUL);

  // analysis: leap test and weekday sum
  logic [YEAR_W-1:0] hundred;
  logic              r_zero;
  logic              dec;
  logic [YEAR_W-1:0] yy;
  logic [6:0]        q_yy;
  logic [14:0]       sum;
  logic              leap;

  assign hundred = 14'(q_y_q) * CENTURY;
  assign r_zero  = (w_year_q == hundred);
  assign dec     = (w_month_q < MONTH_MAR) && (w_year_q != '0);
  assign yy      = w_year_q - {13'd0, dec};
  assign q_yy    = q_y_q - {6'd0, dec & r_zero};
  assign leap    = (w_year_q[1:0] == 2'b00) && (!r_zero || (q_y_q[1:0] == 2'b00));
  assign sum     = 15'(yy) + 15'(yy >> 2) - 15'(q_yy) + 15'(q_yy >> 2)
                 + 15'(month_code(w_month_q)) + 15'(w_day_q);

  // analysis: mod 7
  logic [29:0]       prod7;
  logic [11:0]       q7;
  logic [YEAR_W-1:0] rem7;
  assign prod7 = 30'(sum_q) * 30'(DIV7_MUL);
  assign q7    = prod7[DIV7_SH+11:DIV7_SH];
  assign rem7  = sum_q - 14'(q7) * WEEK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= in_command_i;
      refused_q <= 1'b0;
      if (in_command_i == CMD_LOAD) begin
        w_year_q  <= ld_year;
        w_month_q <= ld_month;
        w_day_q   <= ld_day;
      end else begin
        w_year_q  <= cur_year_q;
        w_month_q <= cur_month_q;
        w_day_q   <= cur_day_q;
        w_dow_q   <= cur_dow_q;
        w_leap_q  <= cur_leap_q;
      end
    end
    if (cmd_i.step) begin
      if (refuse) begin
        refused_q <= 1'b1;
      end else begin
        w_year_q  <= w_year_d;
        w_month_q <= w_month_d;
        w_day_q   <= w_day_d;
      end
    end
    if (cmd_i.clamp && (w_day_q > dim_cur)) begin
      w_day_q <= dim_cur;
    end
    if (cmd_i.div) begin
      q_y_q <= prod_y[DIV100_SH+6:DIV100_SH];
    end
    if (cmd_i.rem) begin
      sum_q    <= sum[YEAR_W-1:0];
      w_leap_q <= leap;
    end
    if (cmd_i.mod7) begin
      w_dow_q <= rem7[DOW_W-1:0];
    end
    if (cmd_i.emit) begin
      out_limit_q <= refused_q;
      if (refused_q) begin
        out_year_q  <= cur_year_q;
        out_month_q <= cur_month_q;
        out_day_q   <= cur_day_q;
        out_dow_q   <= cur_dow_q;
        out_leap_q  <= cur_leap_q;
      end else begin
        out_year_q  <= w_year_q;
        out_month_q <= w_month_q;
        out_day_q   <= w_day_q;
        out_dow_q   <= w_dow_q;
        out_leap_q  <= w_leap_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= RESET_YEAR;
      cur_month_q <= RESET_MONTH;
      cur_day_q   <= RESET_DAY;
      cur_dow_q   <= RESET_DOW;
      cur_leap_q  <= RESET_LEAP;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit && !refused_q) begin
        cur_year_q  <= w_year_q;
        cur_month_q <= w_month_q;
        cur_day_q   <= w_day_q;
        cur_dow_q   <= w_dow_q;
        cur_leap_q  <= w_leap_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.cmd         = cmd_q;
  assign sts_o.step_refuse = refuse;
  assign sts_o.weekday     = (w_dow_q != DOW_SUN) && (w_dow_q != DOW_SAT);
  assign sts_o.out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.year_out     = out_year_q;
  assign out_o.month_out    = out_month_q;
  assign out_o.day_out      = out_day_q;
  assign out_o.day_of_week  = out_dow_q;
  assign out_o.weekday_flag = (out_dow_q != DOW_SUN) && (out_dow_q != DOW_SAT);
  assign out_o.leap_flag    = out_leap_q;
  assign out_o.at_limit     = out_limit_q;

  // committed date is always a real calendar date
  a_cur_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_month_q >= MONTH_FIRST) && (cur_month_q <= MONTH_LAST) &&
    (cur_day_q >= DAY_FIRST) && (cur_day_q <= days_in(cur_month_q, cur_leap_q)))
    else $error("committed date out of range");

  a_cur_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_year_q >= YEAR_MIN) && (cur_year_q <= YEAR_MAX))
    else $error("committed year out of range");

  // a refused command keeps the committed date
  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && refused_q) |=>
      ($stable(cur_year_q) && $stable(cur_month_q) && $stable(cur_day_q) && out_o.at_limit))
    else $error("refused step changed the date");

  // result is only written into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_o.ready))
    else $error("result overwritten before it was taken");

endmodule

/* design/cbds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbds_ctrl
// Sequencer for load, day steps, weekday repeats and the analysis passes.
// ----------------------------------------------------------------------------
module cbds_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [cbds_pkg::CMD_W-1:0]  in_command_i,
  output logic                        in_ready_o,
  output cbds_pkg::cbds_cmd_t         cmd_o,
  input  cbds_pkg::cbds_sts_t         sts_i
);
  import cbds_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_STEP  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_REM   = 8'b0000_1000,
    ST_MOD7  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_CLAMP = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       clamped_q, clamped_d;
  logic       wd_cmd;

  assign wd_cmd = (sts_i.cmd == CMD_NEXT_WD) || (sts_i.cmd == CMD_PREV_WD);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clamped_d  = clamped_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          clamped_d     = 1'b0;
          if (in_command_i == CMD_LOAD) begin
            state_d = ST_DIV;
          end else if ((in_command_i == CMD_NEXT_DAY) || (in_command_i == CMD_PREV_DAY) ||
                       (in_command_i == CMD_NEXT_WD) || (in_command_i == CMD_PREV_WD)) begin
            state_d = ST_STEP;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 3'd1;
        state_d    = sts_i.step_refuse ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_MOD7;
      end
      ST_MOD7: begin
        cmd_o.mod7 = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.cmd == CMD_LOAD) begin
          state_d = clamped_q ? ST_EMIT : ST_CLAMP;
        end else if (wd_cmd && !sts_i.weekday && (cnt_q != 3'd7)) begin
          state_d = ST_STEP;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_CLAMP: begin
        // day limit needs the leap flag of the loaded year
        cmd_o.clamp = 1'b1;
        clamped_d   = 1'b1;
        state_d     = ST_DIV;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      clamped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clamped_q <= clamped_d;
    end
  end

  a_step_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |->
      ((sts_i.cmd == CMD_NEXT_DAY) || (sts_i.cmd == CMD_PREV_DAY) ||
       (sts_i.cmd == CMD_NEXT_WD) || (sts_i.cmd == CMD_PREV_WD)))
    else $error("day step issued for a non-step command");

  a_emit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && !sts_i.out_free) |=> (state_q == ST_EMIT))
    else $error("result dropped while output busy");

  a_plain_step_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STEP) && !wd_cmd) |-> (cnt_q == 3'd0))
    else $error("plain day command stepped twice");

endmodule

/* design/calendar_business_day_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_business_day_stepper
// Gregorian date register with load, day step and weekday step commands.
// ----------------------------------------------------------------------------
// latency depends on the command: a load analyses, clamps, analyses again;
//   a day step analyses once, a weekday step repeats, a refusal skips analysis
// throughput: one transaction at a time; each accepted day step runs the shared
//   analysis sequence (year / 100 by reciprocal multiply, leap test and sum, mod 7)
// a finished result waits in the output register while the next command is taken
// reset (async, active low): date 1970-01-01, thursday, common year, output empty
// ----------------------------------------------------------------------------
module calendar_business_day_stepper (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbds_in_if.sink    in_i,
  cbds_out_if.source out_o
);
  import cbds_pkg::*;

  cbds_cmd_t dp_cmd;
  cbds_sts_t dp_sts;
  logic      in_ready;

  // controller: sequences capture, stepping, analysis passes and result write
  cbds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .cmd_o        (dp_cmd),
    .sts_i        (dp_sts)
  );

  assign in_i.ready = in_ready;

  // datapath: committed and working dates, step logic, analysis, output register
  cbds_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .in_command_i    (in_i.command),
    .in_load_year_i  (in_i.load_year),
    .in_load_month_i (in_i.load_month),
    .in_load_day_i   (in_i.load_day),
    .out_o           (out_o)
  );

endmodule
